FILE: design/vpd_pkg.sv
// ---------------------------------------------------------------------------
// vpd_pkg: shared types and constants for the vapour pressure deficit unit
// Fixed-point constants, the 2^(i/32) table and the item carried from the
// front end to the arithmetic back end.
// ---------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam int unsigned TEMP_W       = 14;
    localparam int unsigned HUM_W        = 14;
    localparam int unsigned OUT_W        = 16;
    localparam int unsigned DEN_W        = 15;
    localparam int unsigned NUM_W        = 32;
    localparam int unsigned QUOT_W       = 18;

    localparam int unsigned DEN_BASE     = 23730;
    localparam int unsigned NUM_SCALE    = 491520;
    localparam int unsigned LOG2_10_Q16  = 217706;
    localparam int unsigned SVP0_DECIPA  = 6107;
    localparam int unsigned RH_FULL      = 10000;
    localparam int unsigned OUT_MAX      = 47500;
    localparam int unsigned HALF_DIV     = 50000;
    localparam int unsigned RECIP_3125   = 351843721;
    localparam int unsigned DIV_LOW      = 3125;

    typedef struct packed {
        logic                neg;
        logic [DEN_W-1:0]    den;
        logic [NUM_W-1:0]    num;
        logic [HUM_W-1:0]    dry;
        logic                ok;
    } vpd_item_t;

    // 2^(i/32) in Q16, i = 0..32
    function automatic logic [17:0] pow2_frac(input logic [5:0] idx);
        logic [17:0] v;
        unique case (idx)
            6'd0:  v = 18'd65536;  6'd1:  v = 18'd66971;  6'd2:  v = 18'd68438;
            6'd3:  v = 18'd69936;  6'd4:  v = 18'd71468;  6'd5:  v = 18'd73032;
            6'd6:  v = 18'd74632;  6'd7:  v = 18'd76266;  6'd8:  v = 18'd77936;
            6'd9:  v = 18'd79642;  6'd10: v = 18'd81386;  6'd11: v = 18'd83169;
            6'd12: v = 18'd84990;  6'd13: v = 18'd86851;  6'd14: v = 18'd88752;
            6'd15: v = 18'd90696;  6'd16: v = 18'd92682;  6'd17: v = 18'd94711;
            6'd18: v = 18'd96785;  6'd19: v = 18'd98905;  6'd20: v = 18'd101070;
            6'd21: v = 18'd103283; 6'd22: v = 18'd105545; 6'd23: v = 18'd107856;
            6'd24: v = 18'd110218; 6'd25: v = 18'd112631; 6'd26: v = 18'd115098;
            6'd27: v = 18'd117618; 6'd28: v = 18'd120194; 6'd29: v = 18'd122825;
            6'd30: v = 18'd125515; 6'd31: v = 18'd128263; 6'd32: v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/vpd_front.sv
// ---------------------------------------------------------------------------
// vpd_front: input stage
// Takes one reading, forms |t|, the divider operands and the dry fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module vpd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vpd_pkg::TEMP_W-1:0]    s_air_temp_centi,
    input  wire logic [vpd_pkg::HUM_W-1:0]     s_rel_humidity_centi,
    input  wire logic                          s_reading_ok,
    output logic                               push,
    output vpd_pkg::vpd_item_t                 push_item,
    input  wire logic                          queue_full
);

    logic               valid_reg;
    vpd_pkg::vpd_item_t item_reg, item_next;
    logic signed [15:0] t_ext;
    logic [15:0]        t_abs;
    logic [15:0]        den_w;

    always_comb begin
        t_ext = {{2{s_air_temp_centi[vpd_pkg::TEMP_W-1]}}, s_air_temp_centi};
        t_abs = t_ext[15] ? 16'(-t_ext) : 16'(t_ext);
        den_w = 16'(vpd_pkg::DEN_BASE) + 16'(t_ext);
        item_next.neg = t_ext[15];
        item_next.den = den_w[vpd_pkg::DEN_W-1:0];
        item_next.num = vpd_pkg::NUM_W'(32'(t_abs) * 32'(vpd_pkg::NUM_SCALE))
                        + vpd_pkg::NUM_W'(den_w[15:1]);
        item_next.dry = (s_rel_humidity_centi >= vpd_pkg::HUM_W'(vpd_pkg::RH_FULL)) ?
                        '0 : vpd_pkg::HUM_W'(vpd_pkg::RH_FULL) - s_rel_humidity_centi;
        item_next.ok  = s_reading_ok;
    end

    assign push      = valid_reg && !queue_full;
    assign s_ready   = !valid_reg || !queue_full;
    assign push_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/vpd_queue.sv
// ---------------------------------------------------------------------------
// vpd_queue: short queue between front and back
// Holds classified items so that each side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module vpd_queue #(
    parameter int unsigned DEPTH = vpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire vpd_pkg::vpd_item_t   push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output vpd_pkg::vpd_item_t        head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    vpd_pkg::vpd_item_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)      count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/vpd_back.sv
// ---------------------------------------------------------------------------
// vpd_back: arithmetic pipeline
// Restoring divider for the Magnus exponent, power of two by table and
// shift, scaling by humidity and final division by 100000 with saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module vpd_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        not_empty,
    input  wire vpd_pkg::vpd_item_t          head_item,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [vpd_pkg::OUT_W-1:0]        m_deficit_pa,
    output logic                             m_deficit_ok
);

    localparam int unsigned QB  = vpd_pkg::QUOT_W;
    localparam int unsigned DW  = vpd_pkg::DEN_W;
    localparam int unsigned HW  = vpd_pkg::HUM_W;

    logic en;

    // divider stages
    logic [DW-1:0] p_reg    [QB+1];
    logic [QB-1:0] rest_reg [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [DW-1:0] den_reg  [QB+1];
    logic          neg_reg  [QB+1];
    logic [HW-1:0] dry_reg  [QB+1];
    logic          ok_reg   [QB+1];
    logic          vld_reg  [QB+1];

    // later stages
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic          ok1_reg, ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok6_reg, ok7_reg, ok8_reg;
    logic          neg1_reg;
    logic [HW-1:0] dry1_reg, dry2_reg, dry3_reg, dry4_reg;
    logic [4:0]    s2_reg, s3_reg, s4_reg, s5_reg;
    logic [19:0]   y_reg;
    logic [17:0]   lo_reg;
    logic [22:0]   prod_reg;
    logic [17:0]   m_reg;
    logic [30:0]   mk_reg;
    logic [44:0]   v_reg;
    logic [33:0]   w_reg;
    logic          sat_reg, sat8_reg;
    logic [27:0]   wd_reg, wd8_reg;
    logic [16:0]   qe_reg;

    logic          out_valid_reg;
    logic [vpd_pkg::OUT_W-1:0] deficit_reg;
    logic          deficit_ok_reg;

    assign en           = !out_valid_reg || m_ready;
    assign pop          = en && not_empty;
    assign m_valid      = out_valid_reg;
    assign m_deficit_pa = deficit_reg;
    assign m_deficit_ok = deficit_ok_reg;

    // load divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= not_empty;
        end
        if (en) begin
            p_reg[0]    <= DW'(head_item.num[vpd_pkg::NUM_W-1:QB]);
            rest_reg[0] <= head_item.num[QB-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= head_item.den;
            neg_reg[0]  <= head_item.neg;
            dry_reg[0]  <= head_item.dry;
            ok_reg[0]   <= head_item.ok;
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < QB; i++) begin : g_div
        logic [DW:0] trial;
        logic        ge;
        always_comb begin
            trial = {p_reg[i], rest_reg[i][QB-1]};
            ge    = (trial >= {1'b0, den_reg[i]});
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                p_reg[i+1]    <= ge ? DW'(trial - {1'b0, den_reg[i]}) : trial[DW-1:0];
                rest_reg[i+1] <= {rest_reg[i][QB-2:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][QB-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                dry_reg[i+1]  <= dry_reg[i];
                ok_reg[i+1]   <= ok_reg[i];
            end
        end
    end

    logic [35:0] y_full;
    logic [20:0] u;
    logic [4:0]  n;
    logic [4:0]  shift;
    logic [4:0]  idx;
    logic [17:0] lo, hi;
    logic [11:0] diff;
    logic [47:0] a_sum;
    logic [56:0] recip_prod;
    logic [31:0] next_mult;
    logic [16:0] q_fix;

    always_comb begin
        y_full     = 36'(q_reg[QB]) * 36'(vpd_pkg::LOG2_10_Q16) + 36'd32768;
        u          = neg1_reg ? (21'h100000 - 21'(y_reg)) : (21'h100000 + 21'(y_reg));
        n          = u[20:16];
        shift      = (n < 5'd2) ? 5'd30 : 5'(6'd32 - 6'(n));
        idx        = u[15:11];
        lo         = vpd_pkg::pow2_frac({1'b0, idx});
        hi         = vpd_pkg::pow2_frac(6'(idx) + 6'd1);
        diff       = 12'(hi - lo);
        a_sum      = 48'(v_reg) + (48'(vpd_pkg::HALF_DIV) << s5_reg);
        recip_prod = 57'(wd_reg) * 57'(vpd_pkg::RECIP_3125);
        next_mult  = (32'(qe_reg) + 32'd1) * 32'(vpd_pkg::DIV_LOW);
        q_fix      = (32'(wd8_reg) >= next_mult) ? qe_reg + 17'd1 : qe_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vld_reg[QB];
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            out_valid_reg <= v8_reg;
        end
        if (en) begin
            // exponent scaled to base two
            y_reg    <= y_full[35:16];
            neg1_reg <= neg_reg[QB];
            dry1_reg <= dry_reg[QB];
            ok1_reg  <= ok_reg[QB];
            // table look-up and interpolation product
            lo_reg   <= lo;
            prod_reg <= 23'(diff) * 23'(u[10:0]);
            s2_reg   <= shift;
            dry2_reg <= dry1_reg;
            ok2_reg  <= ok1_reg;
            m_reg    <= lo_reg + 18'((prod_reg + 23'd1024) >> 11);
            s3_reg   <= s2_reg;
            dry3_reg <= dry2_reg;
            ok3_reg  <= ok2_reg;
            mk_reg   <= 31'(m_reg) * 31'(vpd_pkg::SVP0_DECIPA);
            s4_reg   <= s3_reg;
            dry4_reg <= dry3_reg;
            ok4_reg  <= ok3_reg;
            v_reg    <= 45'(mk_reg) * 45'(dry4_reg);
            s5_reg   <= s4_reg;
            ok5_reg  <= ok4_reg;
            // round and drop the power of two
            w_reg    <= 34'(a_sum >> s5_reg);
            ok6_reg  <= ok5_reg;
            // divide by 32 then by 3125 through a reciprocal
            sat_reg  <= (w_reg >= 34'd4750100000);
            wd_reg   <= w_reg[32:5];
            ok7_reg  <= ok6_reg;
            qe_reg   <= 17'(recip_prod >> 40);
            sat8_reg <= sat_reg;
            wd8_reg  <= wd_reg;
            ok8_reg  <= ok7_reg;
            deficit_ok_reg <= ok8_reg;
            if (!ok8_reg)      deficit_reg <= '0;
            else if (sat8_reg) deficit_reg <= vpd_pkg::OUT_W'(vpd_pkg::OUT_MAX);
            else               deficit_reg <= vpd_pkg::OUT_W'(q_fix);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_deficit_pa <= vpd_pkg::OUT_W'(vpd_pkg::OUT_MAX)))
        else $error("deficit above saturation limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_deficit_ok) |-> (m_deficit_pa == '0))
        else $error("invalid reading gave non-zero deficit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_deficit_pa)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: design/vapor_pressure_deficit.sv
// Throughput: one item per cycle while m_ready is not held low; the 18-stage restoring divider for the
// Magnus exponent is pipelined, so items overlap throughout.
// Stalls on the result side back up into a short queue before s_ready drops.
// Reset: synchronous, active low; clears all valid flags and queue pointers.
// ---------------------------------------------------------------------------
// vapor_pressure_deficit: top level
// Vapour pressure deficit from temperature and humidity, Magnus formula.
// ---------------------------------------------------------------------------
`default_nettype none

module vapor_pressure_deficit #(
    parameter int unsigned QUEUE_DEPTH = vpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vpd_pkg::TEMP_W-1:0]    s_air_temp_centi,
    input  wire logic [vpd_pkg::HUM_W-1:0]     s_rel_humidity_centi,
    input  wire logic                          s_reading_ok,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vpd_pkg::OUT_W-1:0]          m_deficit_pa,
    output logic                               m_deficit_ok
);

    logic               push, full, pop, not_empty;
    vpd_pkg::vpd_item_t push_item, head_item;

    vpd_front u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_air_temp_centi     (s_air_temp_centi),
        .s_rel_humidity_centi (s_rel_humidity_centi),
        .s_reading_ok         (s_reading_ok),
        .push                 (push),
        .push_item            (push_item),
        .queue_full           (full)
    );

    vpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    vpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .not_empty    (not_empty),
        .head_item    (head_item),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_deficit_pa (m_deficit_pa),
        .m_deficit_ok (m_deficit_ok)
    );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: vapour pressure deficit unit testbench
// Drives temperature/humidity items through a table of directed cases, then
// random items, with random idling on both sides and a long receiver stall.
// Every result is checked against zero, a table entry or a fixed-point model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int unsigned LATENCY   = 29;
    localparam int unsigned WATCHDOG  = 20000;
    localparam int unsigned N_RANDOM  = 500;
    localparam int unsigned LONG_HOLD = 200;

    typedef struct {
        logic [vpd_pkg::TEMP_W-1:0] temp;
        logic [vpd_pkg::HUM_W-1:0]  hum;
        logic                       ok;
        logic                       known;
        logic [vpd_pkg::OUT_W-1:0]  pa;
    } reading_t;

    typedef struct {
        logic [vpd_pkg::OUT_W-1:0] pa;
        logic                      ok;
    } deficit_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [vpd_pkg::TEMP_W-1:0]   s_air_temp_centi = '0;
    logic [vpd_pkg::HUM_W-1:0]    s_rel_humidity_centi = '0;
    logic                         s_reading_ok = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [vpd_pkg::OUT_W-1:0]    m_deficit_pa;
    logic                         m_deficit_ok;

    deficit_t   pending_deficits[$];
    reading_t   readings[$];
    int         n_errors = 0;
    int         idle_cycles = 0;
    bit         hold_sink = 1'b0;

    vapor_pressure_deficit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_air_temp_centi     (s_air_temp_centi),
        .s_rel_humidity_centi (s_rel_humidity_centi),
        .s_reading_ok         (s_reading_ok),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_deficit_pa         (m_deficit_pa),
        .m_deficit_ok         (m_deficit_ok)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    localparam logic [31:0] POW2_STEPS[33] = '{
        65536, 66971, 68438, 69936, 71468, 73032, 74632, 76266,
        77936, 79642, 81386, 83169, 84990, 86851, 88752, 90696,
        92682, 94711, 96785, 98905, 101070, 103283, 105545, 107856,
        110218, 112631, 115098, 117618, 120194, 122825, 125515, 128263,
        131072
    };

    // Magnus deficit in whole pascals, saturated
    function automatic logic [vpd_pkg::OUT_W-1:0] magnus_deficit(
        logic [vpd_pkg::TEMP_W-1:0] temp, logic [vpd_pkg::HUM_W-1:0] hum);
        longint t, tmag, den, xmag, ymag, u, n, f, lo, hi, m, dry, s, num, dv, pa;
        t    = longint'($signed(temp));
        tmag = (t < 0) ? -t : t;
        den  = 23730 + t;
        xmag = (tmag * 491520 + den / 2) / den;
        ymag = (xmag * 217706 + 32768) >>> 16;
        u    = (t < 0) ? (1048576 - ymag) : (1048576 + ymag);
        n    = (u >>> 16) & 31;
        f    = u & 16'hFFFF;
        lo   = POW2_STEPS[f >>> 11];
        hi   = POW2_STEPS[(f >>> 11) + 1];
        m    = lo + (((hi - lo) * (f & 11'h7FF) + 1024) >>> 11);
        dry  = (hum >= 10000) ? 0 : 10000 - hum;
        s    = 32 - n;
        if (s > 30) s = 30;
        num  = m * 6107 * dry;
        dv   = 64'd100000 << s;
        pa   = (num + dv / 2) / dv;
        if (pa > 47500) pa = 47500;
        return pa[vpd_pkg::OUT_W-1:0];
    endfunction

    task automatic send_reading(reading_t rd);
        deficit_t exp_d;
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_air_temp_centi     <= rd.temp;
        s_rel_humidity_centi <= rd.hum;
        s_reading_ok         <= rd.ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_d.ok = rd.ok;
        exp_d.pa = !rd.ok ? '0 : (rd.known ? rd.pa : magnus_deficit(rd.temp, rd.hum));
        pending_deficits.push_back(exp_d);
    endtask

    function automatic reading_t mk(int t, int h, bit ok, bit known = 0, int pa = 0);
        reading_t r;
        r.temp  = vpd_pkg::TEMP_W'(t);
        r.hum   = vpd_pkg::HUM_W'(h);
        r.ok    = ok;
        r.known = known;
        r.pa    = vpd_pkg::OUT_W'(pa);
        return r;
    endfunction

    // receiver: random idling per item, plus one long hold requested by the sender
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = hold_sink ? int'(LONG_HOLD) : int'($urandom_range(0, 10));
            hold_sink = 1'b0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        deficit_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            if (pending_deficits.size() == 0) begin
                $error("unexpected result pa=%0d ok=%0b", m_deficit_pa, m_deficit_ok);
                n_errors++;
            end else begin
                exp_d = pending_deficits.pop_front();
                if (m_deficit_pa !== exp_d.pa) begin
                    $error("deficit_pa expected %0d actual %0d", exp_d.pa, m_deficit_pa);
                    n_errors++;
                end
                if (m_deficit_ok !== exp_d.ok) begin
                    $error("deficit_ok expected %0b actual %0b", exp_d.ok, m_deficit_ok);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: count cycles in which nothing is accepted
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        reading_t rd;
        int r;
        // directed table: extremes, invalid reading, humidity over full scale
        readings.push_back(mk(0, 10000, 1, 1, 0));
        readings.push_back(mk(2500, 5000, 0, 1, 0));
        readings.push_back(mk(-8192, 16383, 1, 1, 0));
        readings.push_back(mk(8191, 10001, 1, 1, 0));
        readings.push_back(mk(8191, 0, 1, 1, 47500));
        readings.push_back(mk(8000, 0, 1, 1, 47500));
        readings.push_back(mk(-8192, 0, 1));
        readings.push_back(mk(-4000, 0, 1));
        readings.push_back(mk(-4000, 9999, 1));
        readings.push_back(mk(0, 0, 1));
        readings.push_back(mk(2000, 5000, 1));
        readings.push_back(mk(2500, 4000, 1));
        readings.push_back(mk(-1, 1, 1));
        readings.push_back(mk(1, 8191, 1));
        readings.push_back(mk(8000, 10000, 1, 1, 0));
        readings.push_back(mk(5000, 16383, 0, 1, 0));
        readings.push_back(mk(4321, 2345, 1));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (readings[i]) send_reading(readings[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_sink = 1'b1;
            if (i == 300) begin
                // hold until every expected result is back
                s_valid <= 1'b0;
                wait (pending_deficits.size() == 0);
                @(posedge aclk);
            end
            r = $urandom_range(0, 9);
            if (r < 7) rd = mk(int'($urandom_range(0, 12000)) - 4000,
                               int'($urandom_range(0, 10000)), 1);
            else if (r < 9) rd = mk(int'($urandom_range(0, 16383)) - 8192,
                                    int'($urandom_range(0, 16383)), 1);
            else rd = mk(int'($urandom_range(0, 16383)) - 8192,
                         int'($urandom_range(0, 16383)), 0);
            send_reading(rd);
        end
        s_valid <= 1'b0;

        wait (pending_deficits.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
